### rtl/core/ldcg_pkg.sv
// Shared types and constants of the load driven clock governor.
`default_nettype none

package ldcg_pkg;

   // Field widths of the item, result and register ports.
   localparam int CORE_W     = 3;
   localparam int SRC_W      = 2;
   localparam int MHZ_W      = 20;
   localparam int TICK_W     = 32;
   localparam int LOAD_W     = 11;
   localparam int WANT_W     = 30;
   localparam int PROD_W     = 31;
   localparam int LIMIT_W    = 40;
   localparam int TARGET_W   = 31;
   localparam int SIU_W      = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 40;

   // Load scale: busy fraction in units of 1/1024.
   localparam int LOAD_SHIFT = 10;
   localparam int FULL_LOAD  = 1024;

   // Serial divider step counts and the width of the step counter.
   localparam int LDIV_STEPS = LOAD_SHIFT;
   localparam int WDIV_STEPS = WANT_W;
   localparam int STEP_W     = 5;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_LIMITS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ONLINE_LIMITS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNKNOWN_LIMITS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_TARGET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ONLINE_TARGET  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_UNKNOWN_TARGET = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES        = 3'd6;

   // Power source codes.
   localparam logic [SRC_W-1:0] SRC_BATTERY = 2'd0;
   localparam logic [SRC_W-1:0] SRC_ONLINE  = 2'd1;
   localparam logic [SRC_W-1:0] SRC_UNKNOWN = 2'd2;
   localparam logic [SRC_W-1:0] SRC_SPARE   = 2'd3;

   // Time counter classes, in item order.
   localparam logic [2:0] CLASS_USER      = 3'd0;
   localparam logic [2:0] CLASS_NICE      = 3'd1;
   localparam logic [2:0] CLASS_SYSTEM    = 3'd2;
   localparam logic [2:0] CLASS_INTERRUPT = 3'd3;
   localparam logic [2:0] CLASS_IDLE      = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic ring_access;
      logic accumulate;
      logic load_start;
      logic div_step;
      logic div_load;
      logic mul;
      logic want_start;
      logic emit;
      logic emit_last;
      logic update;
      logic advance;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic cls_last;
      logic load_direct;
      logic leads;
      logic last;
      logic group_open;
      logic tload_zero;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

### rtl/core/ldcg_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module ldcg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 320
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/ldcg_ctrl.sv
// Controller state machine that sequences ring access, division and result output.
`default_nettype none

module ldcg_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire ldcg_pkg::status_type status,
   output ldcg_pkg::cmd_type        cmd
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_READ   = 4'd2;
   localparam logic [3:0] S_ACC    = 4'd3;
   localparam logic [3:0] S_LOAD   = 4'd4;
   localparam logic [3:0] S_LDIV   = 4'd5;
   localparam logic [3:0] S_GROUP  = 4'd6;
   localparam logic [3:0] S_MUL    = 4'd7;
   localparam logic [3:0] S_WSTART = 4'd8;
   localparam logic [3:0] S_WDIV   = 4'd9;
   localparam logic [3:0] S_OUT    = 4'd10;
   localparam logic [3:0] S_UPDATE = 4'd11;
   localparam logic [3:0] S_ADV    = 4'd12;

   logic [3:0]                  state_ff, state_in;
   logic [ldcg_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        phase_ff, phase_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      phase_in = phase_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            cmd.ring_access = 1'b1;
            state_in        = S_ACC;
         end
         S_ACC: begin
            cmd.accumulate = 1'b1;
            state_in       = status.cls_last ? S_LOAD : S_READ;
         end
         S_LOAD: begin
            cmd.load_start = 1'b1;
            step_in        = '0;
            state_in       = status.load_direct ? S_GROUP : S_LDIV;
         end
         S_LDIV: begin
            cmd.div_step = 1'b1;
            cmd.div_load = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == ldcg_pkg::STEP_W'(ldcg_pkg::LDIV_STEPS - 1)) begin
               state_in = S_GROUP;
            end
         end
         S_GROUP: begin
            if (status.leads && status.group_open) begin
               phase_in = 1'b0;
               state_in = S_MUL;
            end else begin
               state_in = S_UPDATE;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_WSTART;
         end
         S_WSTART: begin
            cmd.want_start = 1'b1;
            step_in        = '0;
            state_in       = status.tload_zero ? S_OUT : S_WDIV;
         end
         S_WDIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == ldcg_pkg::STEP_W'(ldcg_pkg::WDIV_STEPS - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = phase_ff;
               state_in      = phase_ff ? S_ADV : S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            if (status.last) begin
               if (status.leads || status.group_open) begin
                  phase_in = 1'b1;
                  state_in = S_MUL;
               end else begin
                  state_in = S_ADV;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ADV: begin
            cmd.advance = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         step_ff  <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/ldcg_dpath.sv
// Datapath: configuration registers, snapshot ring, load and clock arithmetic, result register.
`default_nettype none

module ldcg_dpath #(
   parameter int CORES        = 8,
   parameter int SAMPLES_MAX  = 8,
   parameter int TIME_CLASSES = 5
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ldcg_pkg::cmd_type                   cmd,
   output ldcg_pkg::status_type                     status,
   input  wire logic [ldcg_pkg::CORE_W-1:0]         req_core_index,
   input  wire logic                                req_leads_group,
   input  wire logic [ldcg_pkg::SRC_W-1:0]          req_power_source,
   input  wire logic [ldcg_pkg::MHZ_W-1:0]          req_current_mhz,
   input  wire logic [ldcg_pkg::MHZ_W-1:0]          req_core_min_mhz,
   input  wire logic [ldcg_pkg::MHZ_W-1:0]          req_core_max_mhz,
   input  wire logic [ldcg_pkg::TICK_W-1:0]         req_user_ticks,
   input  wire logic [ldcg_pkg::TICK_W-1:0]         req_nice_ticks,
   input  wire logic [ldcg_pkg::TICK_W-1:0]         req_system_ticks,
   input  wire logic [ldcg_pkg::TICK_W-1:0]         req_interrupt_ticks,
   input  wire logic [ldcg_pkg::TICK_W-1:0]         req_idle_ticks,
   input  wire logic                                req_last_core,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [ldcg_pkg::CORE_W-1:0]         rsp_leader_index,
   output logic      [ldcg_pkg::MHZ_W-1:0]          rsp_new_mhz,
   output logic      [ldcg_pkg::WANT_W-1:0]         rsp_wanted_mhz,
   output logic      [ldcg_pkg::LOAD_W-1:0]         rsp_group_load,
   output logic                                     rsp_clock_changed,
   output logic                                     rsp_last_result,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ldcg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ldcg_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int DEPTH  = SAMPLES_MAX * CORES * TIME_CLASSES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SLOT_W = $clog2(SAMPLES_MAX);
   localparam int CLS_W  = (TIME_CLASSES > 1) ? $clog2(TIME_CLASSES) : 1;
   localparam int CNT_W  = $clog2(SAMPLES_MAX + 1);
   localparam int NW     = (CNT_W > ldcg_pkg::SIU_W) ? CNT_W : ldcg_pkg::SIU_W;

   // Configuration registers.
   logic [ldcg_pkg::LIMIT_W-1:0]  bat_lim_ff, onl_lim_ff, unk_lim_ff;
   logic [ldcg_pkg::TARGET_W-1:0] bat_tgt_ff, onl_tgt_ff, unk_tgt_ff;
   logic [ldcg_pkg::SIU_W-1:0]    siu_ff;

   // Item held for the duration of its work.
   logic [ldcg_pkg::CORE_W-1:0] item_core_ff;
   logic                        item_leads_ff;
   logic [ldcg_pkg::SRC_W-1:0]  item_src_ff;
   logic [ldcg_pkg::MHZ_W-1:0]  item_mhz_ff, item_min_ff, item_max_ff;
   logic [ldcg_pkg::TICK_W-1:0] item_user_ff, item_nice_ff, item_sys_ff;
   logic [ldcg_pkg::TICK_W-1:0] item_irq_ff, item_idle_ff;
   logic                        item_last_ff;

   // Group and ring state.
   logic [SLOT_W-1:0]           ptr_ff;
   logic [ldcg_pkg::CORE_W-1:0] open_leader_ff;
   logic                        open_ff;
   logic [ldcg_pkg::MHZ_W-1:0]  leader_mhz_ff, leader_min_ff, leader_max_ff;
   logic [ldcg_pkg::SRC_W-1:0]  leader_src_ff;
   logic [ldcg_pkg::LOAD_W-1:0] rml_ff;

   // Load accumulation and division.
   logic [ADDR_W-1:0]           clr_ff;
   logic [CLS_W-1:0]            cls_ff;
   logic [ldcg_pkg::TICK_W-1:0] all_ff, idle_ff;
   logic [ldcg_pkg::LOAD_W-1:0] load_ff;
   logic [ldcg_pkg::TICK_W-1:0] rem_ff, dsr_ff;
   logic [ldcg_pkg::WANT_W-1:0] quo_ff;
   logic [ldcg_pkg::PROD_W-1:0] prod_ff;
   logic [ldcg_pkg::LOAD_W-1:0] tload_ff;

   // Result register.
   logic                        rsp_valid_ff;
   logic [ldcg_pkg::CORE_W-1:0] rsp_leader_ff;
   logic [ldcg_pkg::MHZ_W-1:0]  rsp_new_ff;
   logic [ldcg_pkg::WANT_W-1:0] rsp_want_ff;
   logic [ldcg_pkg::LOAD_W-1:0] rsp_load_ff;
   logic                        rsp_changed_ff;
   logic                        rsp_last_ff;

   // Combinational signals.
   logic [NW-1:0]                 siu_ext, n_cnt, p1;
   logic [SLOT_W-1:0]             old_slot;
   logic                          core_ok;
   logic [ldcg_pkg::CORE_W-1:0]   core_sel;
   logic [ADDR_W-1:0]             cur_addr, old_addr, ram_wr_addr;
   logic                          ram_we;
   logic [ldcg_pkg::TICK_W-1:0]   ram_wr_data, ram_rd_data;
   logic [ldcg_pkg::TICK_W-1:0]   cls_val, diff, busy;
   logic                          load_direct;
   logic [ldcg_pkg::TICK_W:0]     r2;
   logic                          div_ge;
   logic [ldcg_pkg::TICK_W-1:0]   rem_nx;
   logic [ldcg_pkg::WANT_W-1:0]   quo_nx;
   logic [ldcg_pkg::LIMIT_W-1:0]  lim_sel;
   logic [ldcg_pkg::TARGET_W-1:0] tgt_sel;
   logic [ldcg_pkg::LOAD_W-1:0]   tload_sat;
   logic [ldcg_pkg::MHZ_W-1:0]    smin, smax, lo, hi, new_mhz;
   logic [ldcg_pkg::WANT_W-1:0]   want, raised;
   logic                          out_free;

   assign csr_ready = 1'b1;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         bat_lim_ff <= 40'd1048576000000;
         onl_lim_ff <= 40'd1048576000000;
         unk_lim_ff <= 40'd1048576000000;
         bat_tgt_ff <= 31'd512;
         onl_tgt_ff <= 31'd384;
         unk_tgt_ff <= 31'd384;
         siu_ff     <= 4'd5;
      end else if (csr_valid) begin
         unique case (csr_index)
            ldcg_pkg::CSR_BATTERY_LIMITS: bat_lim_ff <= csr_data;
            ldcg_pkg::CSR_ONLINE_LIMITS:  onl_lim_ff <= csr_data;
            ldcg_pkg::CSR_UNKNOWN_LIMITS: unk_lim_ff <= csr_data;
            ldcg_pkg::CSR_BATTERY_TARGET: bat_tgt_ff <= csr_data[ldcg_pkg::TARGET_W-1:0];
            ldcg_pkg::CSR_ONLINE_TARGET:  onl_tgt_ff <= csr_data[ldcg_pkg::TARGET_W-1:0];
            ldcg_pkg::CSR_UNKNOWN_TARGET: unk_tgt_ff <= csr_data[ldcg_pkg::TARGET_W-1:0];
            ldcg_pkg::CSR_SAMPLES:        siu_ff     <= csr_data[ldcg_pkg::SIU_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_core_ff  <= req_core_index;
         item_leads_ff <= req_leads_group;
         item_src_ff   <= req_power_source;
         item_mhz_ff   <= req_current_mhz;
         item_min_ff   <= req_core_min_mhz;
         item_max_ff   <= req_core_max_mhz;
         item_user_ff  <= req_user_ticks;
         item_nice_ff  <= req_nice_ticks;
         item_sys_ff   <= req_system_ticks;
         item_irq_ff   <= req_interrupt_ticks;
         item_idle_ff  <= req_idle_ticks;
         item_last_ff  <= req_last_core;
      end
   end

   // Sample count clamp and the oldest slot of the ring.
   assign siu_ext = NW'(siu_ff);
   assign n_cnt   = (siu_ext < NW'(2)) ? NW'(2) :
                    ((siu_ext > NW'(SAMPLES_MAX)) ? NW'(SAMPLES_MAX) : siu_ext);
   assign p1       = NW'(ptr_ff) + NW'(1);
   assign old_slot = (p1 >= n_cnt) ? '0 : SLOT_W'(p1);

   // Ring addresses of the current and the oldest snapshot of this class.
   assign core_ok  = (32'(item_core_ff) < 32'(CORES));
   assign core_sel = core_ok ? item_core_ff : '0;
   assign cur_addr = ADDR_W'((ADDR_W'(ptr_ff) * ADDR_W'(CORES) + ADDR_W'(core_sel))
                     * ADDR_W'(TIME_CLASSES) + ADDR_W'(cls_ff));
   assign old_addr = ADDR_W'((ADDR_W'(old_slot) * ADDR_W'(CORES) + ADDR_W'(core_sel))
                     * ADDR_W'(TIME_CLASSES) + ADDR_W'(cls_ff));

   // Counter value of the class in hand; classes beyond the item's fields read as zero.
   always_comb begin
      case (3'(cls_ff))
         ldcg_pkg::CLASS_USER:      cls_val = item_user_ff;
         ldcg_pkg::CLASS_NICE:      cls_val = item_nice_ff;
         ldcg_pkg::CLASS_SYSTEM:    cls_val = item_sys_ff;
         ldcg_pkg::CLASS_INTERRUPT: cls_val = item_irq_ff;
         ldcg_pkg::CLASS_IDLE:      cls_val = item_idle_ff;
         default:                   cls_val = '0;
      endcase
   end

   // The clearing pass after reset shares the write port with the snapshot store.
   assign ram_we      = cmd.clear_step || (cmd.ring_access && core_ok);
   assign ram_wr_addr = cmd.clear_step ? clr_ff : cur_addr;
   assign ram_wr_data = cmd.clear_step ? '0 : cls_val;

   ldcg_ram #(
      .WIDTH (ldcg_pkg::TICK_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (old_addr),
      .rd_data (ram_rd_data)
   );

   assign diff        = cls_val - ram_rd_data;
   assign busy        = all_ff - idle_ff;
   assign load_direct = !core_ok || (all_ff == '0) || (busy >= all_ff);

   // One restoring division step, shared by the load and the clock divisions.
   assign r2     = {rem_ff, quo_ff[ldcg_pkg::WANT_W-1]};
   assign div_ge = (r2 >= {1'b0, dsr_ff});
   assign rem_nx = div_ge ? ldcg_pkg::TICK_W'(r2 - {1'b0, dsr_ff}) : r2[ldcg_pkg::TICK_W-1:0];
   assign quo_nx = {quo_ff[ldcg_pkg::WANT_W-2:0], div_ge};

   // Settings of the leader's power source.
   always_comb begin
      case (leader_src_ff)
         ldcg_pkg::SRC_BATTERY: begin
            lim_sel = bat_lim_ff;
            tgt_sel = bat_tgt_ff;
         end
         ldcg_pkg::SRC_ONLINE: begin
            lim_sel = onl_lim_ff;
            tgt_sel = onl_tgt_ff;
         end
         default: begin
            lim_sel = unk_lim_ff;
            tgt_sel = unk_tgt_ff;
         end
      endcase
   end

   assign tload_sat = (tgt_sel[ldcg_pkg::LOAD_W-1:0] > ldcg_pkg::LOAD_W'(ldcg_pkg::FULL_LOAD)) ?
                      ldcg_pkg::LOAD_W'(ldcg_pkg::FULL_LOAD) : tgt_sel[ldcg_pkg::LOAD_W-1:0];

   // Target clock and clamping to core and source limits; the maximum wins.
   assign want    = (tload_ff == '0) ?
                    ldcg_pkg::WANT_W'(tgt_sel[ldcg_pkg::TARGET_W-1:ldcg_pkg::LOAD_W]) : quo_ff;
   assign smin    = lim_sel[ldcg_pkg::MHZ_W-1:0];
   assign smax    = lim_sel[2*ldcg_pkg::MHZ_W-1:ldcg_pkg::MHZ_W];
   assign hi      = (leader_max_ff < smax) ? leader_max_ff : smax;
   assign lo      = (leader_min_ff > smin) ? leader_min_ff : smin;
   assign raised  = (want > ldcg_pkg::WANT_W'(lo)) ? want : ldcg_pkg::WANT_W'(lo);
   assign new_mhz = (raised > ldcg_pkg::WANT_W'(hi)) ? hi : raised[ldcg_pkg::MHZ_W-1:0];

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Clearing pass counter, class counter and load accumulation.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         load_ff <= '0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.load_start) begin
            load_ff <= (core_ok && (all_ff != '0) && (busy >= all_ff)) ?
                       ldcg_pkg::LOAD_W'(ldcg_pkg::FULL_LOAD) : '0;
         end else if (cmd.div_step && cmd.div_load) begin
            load_ff <= ldcg_pkg::LOAD_W'(quo_nx[ldcg_pkg::LOAD_SHIFT-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cls_ff  <= '0;
         all_ff  <= '0;
         idle_ff <= '0;
      end else if (cmd.accumulate) begin
         cls_ff <= cls_ff + 1'b1;
         all_ff <= all_ff + diff;
         if (3'(cls_ff) == ldcg_pkg::CLASS_IDLE) begin
            idle_ff <= diff;
         end
      end
   end

   // Divider and multiplier registers.
   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         rem_ff <= busy;
         quo_ff <= '0;
         dsr_ff <= all_ff;
      end else if (cmd.want_start) begin
         rem_ff <= '0;
         quo_ff <= prod_ff[ldcg_pkg::WANT_W-1:0];
         dsr_ff <= ldcg_pkg::TICK_W'(tload_ff);
      end else if (cmd.div_step) begin
         rem_ff <= rem_nx;
         quo_ff <= quo_nx;
      end
      if (cmd.mul) begin
         prod_ff  <= {11'd0, leader_mhz_ff} * {20'd0, rml_ff};
         tload_ff <= tload_sat;
      end
   end

   // Group state and ring pointer.
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff         <= '0;
         open_leader_ff <= '0;
         open_ff        <= 1'b0;
         leader_mhz_ff  <= '0;
         leader_min_ff  <= '0;
         leader_max_ff  <= '0;
         leader_src_ff  <= ldcg_pkg::SRC_BATTERY;
         rml_ff         <= '0;
      end else begin
         if (cmd.update) begin
            if (item_leads_ff) begin
               open_leader_ff <= item_core_ff;
               leader_src_ff  <= (item_src_ff == ldcg_pkg::SRC_SPARE) ?
                                 ldcg_pkg::SRC_UNKNOWN : item_src_ff;
               leader_mhz_ff  <= item_mhz_ff;
               leader_min_ff  <= item_min_ff;
               leader_max_ff  <= item_max_ff;
               rml_ff         <= load_ff;
               open_ff        <= 1'b1;
            end else if (open_ff && (load_ff > rml_ff)) begin
               rml_ff <= load_ff;
            end
         end
         if (cmd.emit && cmd.emit_last) begin
            open_ff <= 1'b0;
         end
         if (cmd.advance) begin
            ptr_ff <= old_slot;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_leader_ff  <= open_leader_ff;
         rsp_new_ff     <= new_mhz;
         rsp_want_ff    <= want;
         rsp_load_ff    <= rml_ff;
         rsp_changed_ff <= (new_mhz != leader_mhz_ff);
         rsp_last_ff    <= cmd.emit_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_leader_index  = rsp_leader_ff;
   assign rsp_new_mhz       = rsp_new_ff;
   assign rsp_wanted_mhz    = rsp_want_ff;
   assign rsp_group_load    = rsp_load_ff;
   assign rsp_clock_changed = rsp_changed_ff;
   assign rsp_last_result   = rsp_last_ff;

   // Status back to the controller.
   always_comb begin
      status             = '0;
      status.clear_done  = (clr_ff == ADDR_W'(DEPTH - 1));
      status.cls_last    = (cls_ff == CLS_W'(TIME_CLASSES - 1));
      status.load_direct = load_direct;
      status.leads       = item_leads_ff;
      status.last        = item_last_ff;
      status.group_open  = open_ff;
      status.tload_zero  = (tload_ff == '0);
      status.out_free    = out_free;
   end

`ifndef SYNTHESIS
   // A result is never loaded over one that is still waiting.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result loaded while output register busy");

   // Accumulation uses the read data of the ring access just before it.
   a_acc_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.accumulate |-> $past(cmd.ring_access))
      else $error("accumulate without preceding ring read");

   // The closing result of a poll leaves no group open.
   a_close: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.emit_last) |=> !open_ff)
      else $error("group still open after closing result");

   // A busy fraction never exceeds full load.
   a_load_range: assert property (@(posedge clock) disable iff (reset)
      (load_ff <= ldcg_pkg::LOAD_W'(ldcg_pkg::FULL_LOAD)) &&
      (rml_ff <= ldcg_pkg::LOAD_W'(ldcg_pkg::FULL_LOAD)))
      else $error("load above full scale");
`endif

endmodule

`default_nettype wire

### rtl/core/load_driven_clock_governor.sv
// Top level of the load driven clock governor: controller and datapath.
// Each item is accepted, then read from the ring and accumulated class by class; the load
// division runs unless the load is direct. Each result takes a multiply, a start, the 30-step
// clock division (skipped in fixed mode) and output; the ring advances at the end of a poll,
// and a stall of the result port holds the flow. Items are taken one at a time.
// Reset: control and configuration registers return to their defaults, then the snapshot
// ring (SAMPLES_MAX*CORES*TIME_CLASSES entries, 320 by default) is cleared one entry a cycle
// with req_ready low; configuration writes are taken throughout.
`default_nettype none

module load_driven_clock_governor #(
   parameter int CORES        = 8,
   parameter int SAMPLES_MAX  = 8,
   parameter int TIME_CLASSES = 5
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [ldcg_pkg::CORE_W-1:0]     req_core_index,
   input  wire logic                            req_leads_group,
   input  wire logic [ldcg_pkg::SRC_W-1:0]      req_power_source,
   input  wire logic [ldcg_pkg::MHZ_W-1:0]      req_current_mhz,
   input  wire logic [ldcg_pkg::MHZ_W-1:0]      req_core_min_mhz,
   input  wire logic [ldcg_pkg::MHZ_W-1:0]      req_core_max_mhz,
   input  wire logic [ldcg_pkg::TICK_W-1:0]     req_user_ticks,
   input  wire logic [ldcg_pkg::TICK_W-1:0]     req_nice_ticks,
   input  wire logic [ldcg_pkg::TICK_W-1:0]     req_system_ticks,
   input  wire logic [ldcg_pkg::TICK_W-1:0]     req_interrupt_ticks,
   input  wire logic [ldcg_pkg::TICK_W-1:0]     req_idle_ticks,
   input  wire logic                            req_last_core,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [ldcg_pkg::CORE_W-1:0]     rsp_leader_index,
   output logic      [ldcg_pkg::MHZ_W-1:0]      rsp_new_mhz,
   output logic      [ldcg_pkg::WANT_W-1:0]     rsp_wanted_mhz,
   output logic      [ldcg_pkg::LOAD_W-1:0]     rsp_group_load,
   output logic                                 rsp_clock_changed,
   output logic                                 rsp_last_result,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [ldcg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ldcg_pkg::CSR_DATA_W-1:0] csr_data
);

   ldcg_pkg::cmd_type    cmd;
   ldcg_pkg::status_type status;

   // Sequencer.
   ldcg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and arithmetic.
   ldcg_dpath #(
      .CORES        (CORES),
      .SAMPLES_MAX  (SAMPLES_MAX),
      .TIME_CLASSES (TIME_CLASSES)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_core_index      (req_core_index),
      .req_leads_group     (req_leads_group),
      .req_power_source    (req_power_source),
      .req_current_mhz     (req_current_mhz),
      .req_core_min_mhz    (req_core_min_mhz),
      .req_core_max_mhz    (req_core_max_mhz),
      .req_user_ticks      (req_user_ticks),
      .req_nice_ticks      (req_nice_ticks),
      .req_system_ticks    (req_system_ticks),
      .req_interrupt_ticks (req_interrupt_ticks),
      .req_idle_ticks      (req_idle_ticks),
      .req_last_core       (req_last_core),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_leader_index    (rsp_leader_index),
      .rsp_new_mhz         (rsp_new_mhz),
      .rsp_wanted_mhz      (rsp_wanted_mhz),
      .rsp_group_load      (rsp_group_load),
      .rsp_clock_changed   (rsp_clock_changed),
      .rsp_last_result     (rsp_last_result),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

endmodule

`default_nettype wire

### dv/load_driven_clock_governor_tb.sv
// Self-checking testbench of the load driven clock governor.
`timescale 1ns / 100ps

module load_driven_clock_governor_tb;

   localparam int NCORE      = 8;
   localparam int NSAMP      = 8;
   localparam int NCLASS     = 5;
   localparam int SETTLE     = 200;
   localparam int STALL_MAX  = 6000;
   localparam int PHASE_ITEMS = 300;
   localparam logic [ldcg_pkg::MHZ_W-1:0] MHZ_TOP = 20'd1000000;

   typedef struct packed {
      logic [ldcg_pkg::CORE_W-1:0] core;
      logic                        leads;
      logic [ldcg_pkg::SRC_W-1:0]  source;
      logic [ldcg_pkg::MHZ_W-1:0]  cur_mhz;
      logic [ldcg_pkg::MHZ_W-1:0]  min_mhz;
      logic [ldcg_pkg::MHZ_W-1:0]  max_mhz;
      logic [ldcg_pkg::TICK_W-1:0] user_t;
      logic [ldcg_pkg::TICK_W-1:0] nice_t;
      logic [ldcg_pkg::TICK_W-1:0] sys_t;
      logic [ldcg_pkg::TICK_W-1:0] irq_t;
      logic [ldcg_pkg::TICK_W-1:0] idle_t;
      logic                        last;
   } poll_item_type;

   typedef struct packed {
      logic [ldcg_pkg::CORE_W-1:0] leader;
      logic [ldcg_pkg::MHZ_W-1:0]  new_mhz;
      logic [ldcg_pkg::WANT_W-1:0] wanted;
      logic [ldcg_pkg::LOAD_W-1:0] load;
      logic                        changed;
      logic                        last;
   } decision_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   poll_item_type drive_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   decision_type seen;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [ldcg_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ldcg_pkg::CSR_DATA_W-1:0] csr_data = '0;

   load_driven_clock_governor DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_core_index(drive_item.core), .req_leads_group(drive_item.leads),
      .req_power_source(drive_item.source), .req_current_mhz(drive_item.cur_mhz),
      .req_core_min_mhz(drive_item.min_mhz), .req_core_max_mhz(drive_item.max_mhz),
      .req_user_ticks(drive_item.user_t), .req_nice_ticks(drive_item.nice_t),
      .req_system_ticks(drive_item.sys_t), .req_interrupt_ticks(drive_item.irq_t),
      .req_idle_ticks(drive_item.idle_t), .req_last_core(drive_item.last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_leader_index(seen.leader), .rsp_new_mhz(seen.new_mhz),
      .rsp_wanted_mhz(seen.wanted), .rsp_group_load(seen.load),
      .rsp_clock_changed(seen.changed), .rsp_last_result(seen.last),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   poll_item_type pending_items[$];
   decision_type  decision_q[$];
   int errors = 0;
   int items_taken = 0;
   int decisions_seen = 0;

   // Shadow of the governor state and registers.
   logic [ldcg_pkg::LIMIT_W-1:0]  lim_cfg [3];
   logic [ldcg_pkg::TARGET_W-1:0] tgt_cfg [3];
   logic [ldcg_pkg::SIU_W-1:0]    siu_cfg;
   logic [ldcg_pkg::TICK_W-1:0]   snap [NSAMP*NCORE*NCLASS];
   int unsigned ring_ptr;
   logic [ldcg_pkg::CORE_W-1:0] grp_leader;
   logic grp_open;
   logic [ldcg_pkg::MHZ_W-1:0] grp_mhz, grp_min, grp_max;
   logic [ldcg_pkg::SRC_W-1:0] grp_src;
   logic [ldcg_pkg::LOAD_W-1:0] grp_load;

   function automatic int unsigned used_samples();
      int unsigned n;
      n = siu_cfg;
      if (n < 2) n = 2;
      if (n > NSAMP) n = NSAMP;
      return n;
   endfunction

   function automatic int unsigned slot_after(int unsigned n);
      return (ring_ptr + 1 >= n) ? 0 : ring_ptr + 1;
   endfunction

   // Stores the snapshot of one core and returns its busy fraction.
   function automatic logic [ldcg_pkg::LOAD_W-1:0] busy_fraction(poll_item_type it);
      logic [ldcg_pkg::TICK_W-1:0] vals [NCLASS];
      logic [ldcg_pkg::TICK_W-1:0] all_d, idle_d, d;
      int unsigned cur_s, old_s, cb, ob;
      longint unsigned q;
      vals[0] = it.user_t; vals[1] = it.nice_t; vals[2] = it.sys_t;
      vals[3] = it.irq_t;  vals[4] = it.idle_t;
      cur_s = (ring_ptr < NSAMP) ? ring_ptr : 0;
      old_s = slot_after(used_samples());
      all_d = '0;
      idle_d = '0;
      for (int i = 0; i < NCLASS; i++) begin
         cb = (cur_s * NCORE + it.core) * NCLASS + i;
         ob = (old_s * NCORE + it.core) * NCLASS + i;
         snap[cb] = vals[i];
         d = vals[i] - snap[ob];
         all_d += d;
         if (i == ldcg_pkg::CLASS_IDLE) idle_d = d;
      end
      if (all_d == 0) return '0;
      q = ({32'd0, all_d - idle_d} << ldcg_pkg::LOAD_SHIFT) / {32'd0, all_d};
      return (q > ldcg_pkg::FULL_LOAD) ? ldcg_pkg::LOAD_W'(ldcg_pkg::FULL_LOAD)
                                       : ldcg_pkg::LOAD_W'(q);
   endfunction

   // Works out the clock decision for the open group.
   function automatic decision_type group_decision(logic last_flag);
      decision_type r;
      logic [ldcg_pkg::LIMIT_W-1:0] lim;
      logic [ldcg_pkg::TARGET_W-1:0] tgt;
      longint unsigned tload, want, smin, smax, lo, hi, nw;
      lim = lim_cfg[grp_src];
      tgt = tgt_cfg[grp_src];
      tload = tgt[10:0];
      if (tload > ldcg_pkg::FULL_LOAD) tload = ldcg_pkg::FULL_LOAD;
      if (tload != 0) want = (longint'(grp_mhz) * grp_load) / tload;
      else want = tgt[30:11];
      smin = lim[19:0];
      smax = lim[39:20];
      hi = (grp_max < smax) ? grp_max : smax;
      lo = (grp_min > smin) ? grp_min : smin;
      nw = (want > lo) ? want : lo;
      if (nw > hi) nw = hi;
      r.leader = grp_leader;
      r.new_mhz = ldcg_pkg::MHZ_W'(nw);
      r.wanted = ldcg_pkg::WANT_W'(want);
      r.load = grp_load;
      r.changed = (ldcg_pkg::MHZ_W'(nw) != grp_mhz);
      r.last = last_flag;
      return r;
   endfunction

   // Updates the shadow for one accepted item and queues its decisions.
   function automatic void predict_decisions(poll_item_type it);
      logic [ldcg_pkg::LOAD_W-1:0] ld;
      ld = busy_fraction(it);
      if (it.leads) begin
         if (grp_open) decision_q.push_back(group_decision(1'b0));
         grp_leader = it.core;
         grp_src = (it.source == ldcg_pkg::SRC_SPARE) ? ldcg_pkg::SRC_UNKNOWN : it.source;
         grp_mhz = it.cur_mhz;
         grp_min = it.min_mhz;
         grp_max = it.max_mhz;
         grp_load = ld;
         grp_open = 1'b1;
      end else if (grp_open && ld > grp_load) begin
         grp_load = ld;
      end
      if (it.last) begin
         if (grp_open) begin
            decision_q.push_back(group_decision(1'b1));
            grp_open = 1'b0;
         end
         ring_ptr = slot_after(used_samples());
      end
   endfunction

   // Register shadow follows every accepted write.
   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 3; s++) lim_cfg[s] <= 40'd1048576000000;
         tgt_cfg[ldcg_pkg::SRC_BATTERY] <= 31'd512;
         tgt_cfg[ldcg_pkg::SRC_ONLINE] <= 31'd384;
         tgt_cfg[ldcg_pkg::SRC_UNKNOWN] <= 31'd384;
         siu_cfg <= 4'd5;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ldcg_pkg::CSR_BATTERY_LIMITS: lim_cfg[ldcg_pkg::SRC_BATTERY] <= csr_data;
            ldcg_pkg::CSR_ONLINE_LIMITS:  lim_cfg[ldcg_pkg::SRC_ONLINE] <= csr_data;
            ldcg_pkg::CSR_UNKNOWN_LIMITS: lim_cfg[ldcg_pkg::SRC_UNKNOWN] <= csr_data;
            ldcg_pkg::CSR_BATTERY_TARGET:
               tgt_cfg[ldcg_pkg::SRC_BATTERY] <= csr_data[ldcg_pkg::TARGET_W-1:0];
            ldcg_pkg::CSR_ONLINE_TARGET:
               tgt_cfg[ldcg_pkg::SRC_ONLINE] <= csr_data[ldcg_pkg::TARGET_W-1:0];
            ldcg_pkg::CSR_UNKNOWN_TARGET:
               tgt_cfg[ldcg_pkg::SRC_UNKNOWN] <= csr_data[ldcg_pkg::TARGET_W-1:0];
            ldcg_pkg::CSR_SAMPLES:        siu_cfg <= csr_data[ldcg_pkg::SIU_W-1:0];
            default: ;
         endcase
      end
   end

   // Driver: predicts each accepted item, then presents the next after a random gap.
   int gap_left = 0;
   bit gap_burst = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         foreach (snap[i]) snap[i] = '0;
         ring_ptr = 0;
         grp_leader = '0; grp_open = 1'b0; grp_src = ldcg_pkg::SRC_BATTERY;
         grp_mhz = '0; grp_min = '0; grp_max = '0; grp_load = '0;
      end else begin
         if (req_valid && req_ready) begin
            predict_decisions(drive_item);
            items_taken++;
            if ($urandom_range(0, 99) < 3) gap_burst = !gap_burst;
            gap_left = gap_burst ? 0 : $urandom_range(0, 4);
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               drive_item <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each accepted decision and stalls at random.
   int stall_left = 0;
   bit stall_burst = 0;
   always @(posedge clock) begin
      decision_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            decisions_seen++;
            if (decision_q.size() == 0) begin
               $error("unexpected decision for leader %0d", seen.leader);
               errors++;
            end else begin
               want = decision_q.pop_front();
               if (seen.leader !== want.leader) begin
                  $error("leader_index expected %0d got %0d", want.leader, seen.leader);
                  errors++;
               end
               if (seen.new_mhz !== want.new_mhz) begin
                  $error("new_mhz expected %0d got %0d", want.new_mhz, seen.new_mhz);
                  errors++;
               end
               if (seen.wanted !== want.wanted) begin
                  $error("wanted_mhz expected %0d got %0d", want.wanted, seen.wanted);
                  errors++;
               end
               if (seen.load !== want.load) begin
                  $error("group_load expected %0d got %0d", want.load, seen.load);
                  errors++;
               end
               if (seen.changed !== want.changed) begin
                  $error("clock_changed expected %0d got %0d", want.changed, seen.changed);
                  errors++;
               end
               if (seen.last !== want.last) begin
                  $error("last_result expected %0d got %0d", want.last, seen.last);
                  errors++;
               end
            end
            if ($urandom_range(0, 99) < 5) stall_burst = !stall_burst;
            stall_left = stall_burst ? 0 : $urandom_range(0, 4);
         end
         if (stall_left > 0) stall_left--;
         rsp_ready <= (stall_left == 0);
      end
   end

   // Watchdog on cycles without any handshake.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("Watchdog expired after %0d idle cycles", quiet_cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Stimulus generation.
   logic [ldcg_pkg::TICK_W-1:0] running_ticks [NCORE][NCLASS];

   function automatic poll_item_type make_core(int core, bit leads, bit last, bit noisy);
      poll_item_type it;
      logic [ldcg_pkg::TICK_W-1:0] t [NCLASS];
      int unsigned lo_m, hi_m;
      it = '0;
      it.core = ldcg_pkg::CORE_W'(core);
      it.leads = leads;
      it.last = last;
      it.source = ldcg_pkg::SRC_W'($urandom_range(0, 3));
      it.cur_mhz = ldcg_pkg::MHZ_W'($urandom_range(0, MHZ_TOP));
      lo_m = $urandom_range(0, MHZ_TOP);
      hi_m = $urandom_range(0, MHZ_TOP);
      if ($urandom_range(0, 9) != 0 && lo_m > hi_m) begin
         it.min_mhz = ldcg_pkg::MHZ_W'(hi_m); it.max_mhz = ldcg_pkg::MHZ_W'(lo_m);
      end else begin
         it.min_mhz = ldcg_pkg::MHZ_W'(lo_m); it.max_mhz = ldcg_pkg::MHZ_W'(hi_m);
      end
      for (int c = 0; c < NCLASS; c++) begin
         if (noisy) running_ticks[core][c] = $urandom();
         else running_ticks[core][c] += $urandom_range(0, 1 << $urandom_range(0, 16));
         t[c] = running_ticks[core][c];
      end
      it.user_t = t[0]; it.nice_t = t[1]; it.sys_t = t[2];
      it.irq_t = t[3]; it.idle_t = t[4];
      return it;
   endfunction

   // Queues one poll: ascending cores, mostly well formed.
   task automatic queue_poll();
      int core, n;
      bit broken, noisy;
      poll_item_type it;
      broken = ($urandom_range(0, 9) == 0);
      noisy = ($urandom_range(0, 7) == 0);
      core = $urandom_range(0, 3);
      n = 0;
      while (core < NCORE) begin
         it = make_core(core, (n == 0) ? ($urandom_range(0, 9) != 0)
                                       : ($urandom_range(0, 3) == 0), 1'b0, noisy);
         n++;
         core += $urandom_range(1, 2);
         if (core >= NCORE || $urandom_range(0, 7) == 0) it.last = !broken;
         if (broken && $urandom_range(0, 5) == 0) it.last = 1'b1;
         pending_items.push_back(it);
         if (it.last) break;
      end
   endtask

   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || decision_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [ldcg_pkg::CSR_IDX_W-1:0] idx,
                            logic [ldcg_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [ldcg_pkg::CSR_DATA_W-1:0] rand_limits();
      return {ldcg_pkg::MHZ_W'($urandom_range(300000, MHZ_TOP)),
              ldcg_pkg::MHZ_W'($urandom_range(0, 400000))};
   endfunction

   function automatic logic [ldcg_pkg::CSR_DATA_W-1:0] rand_target();
      logic [ldcg_pkg::CSR_DATA_W-1:0] v;
      v = '0;
      v[30:11] = ldcg_pkg::MHZ_W'($urandom_range(0, MHZ_TOP));
      v[10:0] = ($urandom_range(0, 4) == 0) ? 11'd0 : 11'($urandom_range(1, 1024));
      return v;
   endfunction

   // Directed items, register phases and random polls.
   initial begin
      poll_item_type it;
      logic [ldcg_pkg::CSR_DATA_W-1:0] tv;
      foreach (running_ticks[i, c]) running_ticks[i][c] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Non-leader and last core with no group open.
      pending_items.push_back(make_core(0, 1'b0, 1'b0, 1'b0));
      pending_items.push_back(make_core(1, 1'b0, 1'b1, 1'b0));
      // Zero counters, then all-ones counters, extreme clocks, every source.
      for (int s = 0; s < 4; s++) begin
         it = '0;
         it.core = ldcg_pkg::CORE_W'(2 * s);
         it.leads = 1'b1;
         it.source = ldcg_pkg::SRC_W'(s);
         it.cur_mhz = (s[0]) ? MHZ_TOP : '0;
         it.max_mhz = MHZ_TOP;
         pending_items.push_back(it);
         it.core = ldcg_pkg::CORE_W'(2 * s + 1);
         it.leads = 1'b0;
         it.user_t = '1; it.nice_t = '1; it.sys_t = '1; it.irq_t = '1; it.idle_t = '1;
         it.last = (s == 3);
         pending_items.push_back(it);
      end
      // Idle counter running backwards drives the busy fraction above full.
      it = make_core(7, 1'b1, 1'b0, 1'b0);
      it.min_mhz = MHZ_TOP;
      it.max_mhz = '0;
      it.idle_t = it.idle_t - 32'd100000;
      it.user_t = it.user_t + 32'd5;
      pending_items.push_back(it);
      it = make_core(7, 1'b1, 1'b1, 1'b0);
      it.idle_t = 32'hFFFF_FFFF;
      pending_items.push_back(it);

      // Six register settings, extremes among them.
      for (int ph = 0; ph < 6; ph++) begin
         if (ph != 0) begin
            wait_idle();
            for (int s = 0; s < 3; s++) begin
               case (ph)
                  1: tv = '1;
                  2: tv = '0;
                  default: tv = rand_limits();
               endcase
               write_reg(ldcg_pkg::CSR_BATTERY_LIMITS + ldcg_pkg::CSR_IDX_W'(s), tv);
               case (ph)
                  1: tv = 40'd1;
                  2: tv = 40'h7FFF_F800;
                  3: tv = 40'h7FFF_FFFF;
                  default: tv = rand_target();
               endcase
               write_reg(ldcg_pkg::CSR_BATTERY_TARGET + ldcg_pkg::CSR_IDX_W'(s), tv);
            end
            case (ph)
               1: tv = 40'd2;
               2: tv = 40'd8;
               3: tv = 40'd0;
               4: tv = 40'd15;
               default: tv = 40'd1;
            endcase
            write_reg(ldcg_pkg::CSR_SAMPLES, tv);
         end
         for (int k = 0; k < PHASE_ITEMS; ) begin
            while (pending_items.size() > 16) @(posedge clock);
            k -= pending_items.size();
            queue_poll();
            k += pending_items.size();
         end
      end

      wait_idle();
      $display("Covered %0d items and %0d clock decisions over six register settings,",
               items_taken, decisions_seen);
      $display("including fixed and adaptive modes, saturated loads and sample counts.");
      if (errors == 0 && decision_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
